// ===== hdl/gacp_pkg.sv =====
// Package for the gamepad axis calibrate and pack block.
// Holds shared constants, register indexes and a helper function; no dependencies.
package gacp_pkg;

    localparam logic [7:0] STICK_LO     = 8'h20;
    localparam logic [7:0] STICK_SPAN   = 8'hC0;
    localparam logic [7:0] TRIG_LO      = 8'h20;
    localparam logic [7:0] TRIG_SPAN    = 8'hDF;
    localparam logic [7:0] TRIG_HI      = 8'hFF;
    localparam logic [7:0] STICK_CENTER = 8'h7F;

    localparam logic [2:0] REG_LEFT_BOUNDS    = 3'd0;
    localparam logic [2:0] REG_RIGHT_BOUNDS   = 3'd1;
    localparam logic [2:0] REG_LEFT_DEADZONE  = 3'd2;
    localparam logic [2:0] REG_RIGHT_DEADZONE = 3'd3;
    localparam logic [2:0] REG_INVERT_MASK    = 3'd4;
    localparam logic [2:0] REG_ENABLE_MASK    = 3'd5;
    localparam logic [2:0] REG_FULL_REPORT    = 3'd6;

    // (v, or ~v when inv is set) * span / 255 + lo, with v and span at most 8 bits.
    // x/255 for x < 65535: (x + 1 + (x >> 8)) >> 8.
    function automatic logic [7:0] rescale(input logic [7:0] v, input logic inv,
                                           input logic [7:0] span, input logic [7:0] lo);
        logic [7:0]  w;
        logic [15:0] p;
        logic [16:0] q;
        begin
            w = inv ? ~v : v;
            p = w * span;
            q = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
            rescale = q[15:8] + lo;
        end
    endfunction

endpackage

// ===== hdl/gacp_stick_lane.sv =====
// One stick lane: deadzone centering, clamp, stretch (pipelined restoring divider), invert and rescale.
// Depends on gacp_pkg.
module gacp_stick_lane
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic [31:0] bounds,
    input  logic [7:0] deadzone,
    input  logic       enable,
    input  logic       inv_x,
    input  logic       inv_y,
    output logic       out_valid,
    output logic [7:0] out_x,
    output logic [7:0] out_y
);
    import gacp_pkg::*;

    localparam int STEPS = 16;

    typedef struct packed {
        logic [15:0] num;
        logic [7:0]  den;
        logic [15:0] quo;
        logic [16:0] rem;
        logic        direct;
        logic [7:0]  dval;
    } div_t;

    logic [STEPS:0]  valid_reg;
    logic [STEPS:0]  center_reg;
    logic [STEPS:0]  invx_reg;
    logic [STEPS:0]  invy_reg;
    div_t            dx_reg [STEPS+1];
    div_t            dy_reg [STEPS+1];
    logic [7:0]      out_x_reg;
    logic [7:0]      out_y_reg;
    logic            out_valid_reg;

    function automatic div_t div_init(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        div_t d;
        begin
            d = '0;
            if (v < lo)
            begin
                d.direct = 1'b1;
                d.dval = 8'd0;
            end
            else if (v > hi)
            begin
                d.direct = 1'b1;
                d.dval = 8'd255;
            end
            else if (hi == lo)
            begin
                d.direct = 1'b1;
                d.dval = 8'd0;
            end
            else
            begin
                d.num = (v - lo) * 8'd255;
                d.den = hi - lo;
            end
            div_init = d;
        end
    endfunction

    function automatic div_t div_step(input div_t d, input int k);
        div_t   o;
        logic [16:0] r;
        begin
            o = d;
            r = {d.rem[15:0], d.num[STEPS-1-k]};
            if (r >= {9'd0, d.den})
            begin
                o.rem = r - {9'd0, d.den};
                o.quo[STEPS-1-k] = 1'b1;
            end
            else
            begin
                o.rem = r;
            end
            div_step = o;
        end
    endfunction

    logic signed [8:0]  ddx, ddy;
    logic        [17:0] d2;
    logic        [15:0] r2;
    assign ddx = $signed({1'b0, x}) - 9'sd128;
    assign ddy = $signed({1'b0, y}) - 9'sd128;
    assign d2  = 18'(ddx * ddx) + 18'(ddy * ddy);
    assign r2  = deadzone * deadzone;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
            out_valid_reg <= valid_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg[0] <= !enable || (d2 < {2'd0, r2});
        invx_reg[0] <= inv_x;
        invy_reg[0] <= inv_y;
        dx_reg[0] <= div_init(x, bounds[7:0], bounds[23:16]);
        dy_reg[0] <= div_init(y, bounds[15:8], bounds[31:24]);
        for (int k = 0; k < STEPS; k++)
        begin
            center_reg[k+1] <= center_reg[k];
            invx_reg[k+1] <= invx_reg[k];
            invy_reg[k+1] <= invy_reg[k];
            dx_reg[k+1] <= div_step(dx_reg[k], k);
            dy_reg[k+1] <= div_step(dy_reg[k], k);
        end
        if (center_reg[STEPS])
        begin
            out_x_reg <= STICK_CENTER;
            out_y_reg <= STICK_CENTER;
        end
        else
        begin
            out_x_reg <= rescale(dx_reg[STEPS].direct ? dx_reg[STEPS].dval
                                 : dx_reg[STEPS].quo[7:0], invx_reg[STEPS],
                                 STICK_SPAN, STICK_LO);
            out_y_reg <= rescale(dy_reg[STEPS].direct ? dy_reg[STEPS].dval
                                 : dy_reg[STEPS].quo[7:0], invy_reg[STEPS],
                                 STICK_SPAN, STICK_LO);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
endmodule

// ===== hdl/gacp_pack.sv =====
// Merge stage: triggers, buttons and full or compact report packing.
// Depends on gacp_pkg.
module gacp_pack
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] lx,
    input  logic [7:0] ly,
    input  logic [7:0] rx,
    input  logic [7:0] ry,
    input  logic [7:0] lt,
    input  logic [7:0] rt,
    input  logic [14:0] buttons,
    input  logic       full,
    output logic       out_valid,
    output logic [63:0] bytes_out,
    output logic [3:0] length
);
    import gacp_pkg::*;

    logic        valid_reg;
    logic [63:0] bytes_reg;
    logic [3:0]  length_reg;
    logic [7:0]  hi_btn, lo_btn;
    logic [5:0]  clx, cly;
    logic [4:0]  crx, cry, clt, crt;

    assign hi_btn = {buttons[14:8], 1'b1};
    assign lo_btn = buttons[7:0];
    assign clx = lx[7:2];
    assign cly = ly[7:2];
    assign crx = rx[7:3];
    assign cry = ry[7:3];
    assign clt = lt[7:3];
    assign crt = rt[7:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (full)
        begin
            bytes_reg <= {lo_btn, hi_btn, rt, lt, ry, ly, rx, lx};
            length_reg <= 4'd8;
        end
        else
        begin
            bytes_reg <= {8'd0, 8'd0, lo_btn, hi_btn,
                          clt[2:0], crt,
                          crx[0], clt[4:3], cry,
                          crx[2:1], cly,
                          crx[4:3], clx};
            length_reg <= 4'd6;
        end
    end

    assign out_valid = valid_reg;
    assign bytes_out = bytes_reg;
    assign length = length_reg;
endmodule

// ===== hdl/gamepad_axis_calibrate_and_pack.sv =====
// Top level of the gamepad axis calibrate and pack block.
// Depends on gacp_pkg, gacp_stick_lane and gacp_pack.
//
// Usage:
//   Raise start with a sample on left_x..button_bits; the request is taken at
//   any edge where start is high and busy is low. busy stays low, so one
//   sample can be taken every cycle.
//   Each sample yields one report on byte0..byte7 and report_length, marked by
//   done for exactly one cycle. Reports leave in request order; the receiver
//   cannot stall them. Each stick lane stretches the calibrated range with a
//   16-step pipelined divider; each stage retires one quotient bit.
//   Configuration: cfg_we, cfg_index, cfg_data write register cfg_index at
//   the clock edge; write only while no request is in flight.
//   Reset (rst_n low) clears the pipeline and loads the register defaults:
//   bounds 0xFFFF0000, deadzones 10, no inversion, both sticks enabled,
//   analog triggers off, compact report.
module gamepad_axis_calibrate_and_pack
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    input  logic [7:0]  left_trigger,
    input  logic [7:0]  right_trigger,
    input  logic [14:0] button_bits,
    output logic [7:0]  byte0,
    output logic [7:0]  byte1,
    output logic [7:0]  byte2,
    output logic [7:0]  byte3,
    output logic [7:0]  byte4,
    output logic [7:0]  byte5,
    output logic [7:0]  byte6,
    output logic [7:0]  byte7,
    output logic [3:0]  report_length
);
    import gacp_pkg::*;

    localparam int DLY = 18;

    logic [31:0] left_bounds_reg, right_bounds_reg;
    logic [7:0]  left_deadzone_reg, right_deadzone_reg;
    logic [5:0]  invert_mask_reg;
    logic [2:0]  enable_mask_reg;
    logic        full_report_reg;

    logic        accept;
    logic        lv, rv;
    logic [7:0]  lx, ly, rx, ry;
    logic [7:0]  lt_reg [DLY];
    logic [7:0]  rt_reg [DLY];
    logic [14:0] btn_reg [DLY];
    logic [7:0]  lt_first, rt_first;
    logic [63:0] bytes_w;

    assign accept = start;
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_bounds_reg <= 32'hFFFF0000;
            right_bounds_reg <= 32'hFFFF0000;
            left_deadzone_reg <= 8'd10;
            right_deadzone_reg <= 8'd10;
            invert_mask_reg <= 6'd0;
            enable_mask_reg <= 3'd3;
            full_report_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT_BOUNDS:    left_bounds_reg <= cfg_data;
                REG_RIGHT_BOUNDS:   right_bounds_reg <= cfg_data;
                REG_LEFT_DEADZONE:  left_deadzone_reg <= cfg_data[7:0];
                REG_RIGHT_DEADZONE: right_deadzone_reg <= cfg_data[7:0];
                REG_INVERT_MASK:    invert_mask_reg <= cfg_data[5:0];
                REG_ENABLE_MASK:    enable_mask_reg <= cfg_data[2:0];
                REG_FULL_REPORT:    full_report_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    gacp_stick_lane u_left
    (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .x(left_x), .y(left_y), .bounds(left_bounds_reg),
        .deadzone(left_deadzone_reg), .enable(enable_mask_reg[0]),
        .inv_x(invert_mask_reg[0]), .inv_y(invert_mask_reg[1]),
        .out_valid(lv), .out_x(lx), .out_y(ly)
    );

    gacp_stick_lane u_right
    (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .x(right_x), .y(right_y), .bounds(right_bounds_reg),
        .deadzone(right_deadzone_reg), .enable(enable_mask_reg[1]),
        .inv_x(invert_mask_reg[2]), .inv_y(invert_mask_reg[3]),
        .out_valid(rv), .out_x(rx), .out_y(ry)
    );

    // Triggers: rescale or button level at entry, delayed to match sticks.
    always_comb
    begin
        if (!enable_mask_reg[2])
        begin
            lt_first = button_bits[12] ? TRIG_LO : TRIG_HI;
            rt_first = button_bits[8] ? TRIG_LO : TRIG_HI;
        end
        else
        begin
            lt_first = rescale(left_trigger, invert_mask_reg[4], TRIG_SPAN, TRIG_LO);
            rt_first = rescale(right_trigger, invert_mask_reg[5], TRIG_SPAN, TRIG_LO);
        end
    end

    always_ff @(posedge clk)
    begin
        lt_reg[0] <= lt_first;
        rt_reg[0] <= rt_first;
        btn_reg[0] <= button_bits;
        for (int k = 1; k < DLY; k++)
        begin
            lt_reg[k] <= lt_reg[k-1];
            rt_reg[k] <= rt_reg[k-1];
            btn_reg[k] <= btn_reg[k-1];
        end
    end

    gacp_pack u_pack
    (
        .clk(clk), .rst_n(rst_n), .in_valid(lv & rv),
        .lx(lx), .ly(ly), .rx(rx), .ry(ry),
        .lt(lt_reg[DLY-1]), .rt(rt_reg[DLY-1]), .buttons(btn_reg[DLY-1]),
        .full(full_report_reg),
        .out_valid(done), .bytes_out(bytes_w), .length(report_length)
    );

    assign byte0 = bytes_w[7:0];
    assign byte1 = bytes_w[15:8];
    assign byte2 = bytes_w[23:16];
    assign byte3 = bytes_w[31:24];
    assign byte4 = bytes_w[39:32];
    assign byte5 = bytes_w[47:40];
    assign byte6 = bytes_w[55:48];
    assign byte7 = bytes_w[63:56];
endmodule

// ===== bench/gamepad_axis_calibrate_and_pack_test.sv =====
// Self-checking bench for gamepad_axis_calibrate_and_pack: calibration, deadzone and packing.
// Drives samples and register writes, predicts each report and compares it as a whole.
// Depends on gacp_pkg and the block's RTL.
`timescale 1ns / 1ps

module gamepad_axis_calibrate_and_pack_test;
    import gacp_pkg::*;

    typedef struct packed {
        logic [7:0]  lx, ly, rx, ry, lt, rt;
        logic [14:0] btn;
    } sample_t;

    typedef struct packed {
        logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
        logic [3:0] len;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic [7:0]  left_x = '0, left_y = '0, right_x = '0, right_y = '0;
    logic [7:0]  left_trigger = '0, right_trigger = '0;
    logic [14:0] button_bits = '0;
    logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
    logic [3:0]  report_length;

    gamepad_axis_calibrate_and_pack u_top (.*);

    // Shadow of the register file.
    logic [31:0] lbounds, rbounds;
    logic [7:0]  ldz, rdz;
    logic [5:0]  inv_bits;
    logic [2:0]  en_bits;
    logic        full_mode;

    sample_t pending_samples[$];
    report_t expected_reports[$];
    int      idle_pct = 0;
    int      mismatches = 0;
    int      reports_seen = 0;
    int      samples_sent = 0;
    longint  cycle_count = 0;

    function automatic int stretch_axis(int v, int lo, int hi);
        if (v < lo) return 0;
        if (v > hi) return 255;
        if (hi == lo) return 0;
        return ((v - lo) * 255) / (hi - lo);
    endfunction

    function automatic int map_range(int v, logic inv, int lo, int hi);
        if (inv) v = 255 - v;
        return (v * (hi - lo)) / 255 + lo;
    endfunction

    function automatic void calibrate_stick(int x, int y, logic [31:0] bnd, int dz,
                                            logic en, logic ix, logic iy,
                                            output int ox, output int oy);
        int dx, dy;
        dx = x - 128;
        dy = y - 128;
        if (!en || (dx * dx + dy * dy) < dz * dz) begin
            ox = 'h7F;
            oy = 'h7F;
        end
        else begin
            ox = map_range(stretch_axis(x, bnd[7:0], bnd[23:16]), ix, 'h20, 'hE0);
            oy = map_range(stretch_axis(y, bnd[15:8], bnd[31:24]), iy, 'h20, 'hE0);
        end
    endfunction

    function automatic report_t build_report(sample_t s);
        report_t r;
        int lx, ly, rx, ry, lt, rt;
        logic [7:0] hi_b, lo_b;
        calibrate_stick(s.lx, s.ly, lbounds, ldz, en_bits[0], inv_bits[0], inv_bits[1], lx, ly);
        calibrate_stick(s.rx, s.ry, rbounds, rdz, en_bits[1], inv_bits[2], inv_bits[3], rx, ry);
        if (!en_bits[2]) begin
            lt = s.btn[12] ? 'h20 : 'hFF;
            rt = s.btn[8] ? 'h20 : 'hFF;
        end
        else begin
            lt = map_range(s.lt, inv_bits[4], 'h20, 'hFF);
            rt = map_range(s.rt, inv_bits[5], 'h20, 'hFF);
        end
        hi_b = {s.btn[14:8], 1'b1};
        lo_b = s.btn[7:0];
        if (full_mode) begin
            r = '{8'(lx), 8'(rx), 8'(ly), 8'(ry), 8'(lt), 8'(rt), hi_b, lo_b, 4'd8};
        end
        else begin
            lx = lx >> 2; ly = ly >> 2; rx = rx >> 3; ry = ry >> 3; lt = lt >> 3; rt = rt >> 3;
            r.b0 = 8'(((rx << 3) & 'hC0) | (lx & 'h3F));
            r.b1 = 8'(((rx << 5) & 'hC0) | (ly & 'h3F));
            r.b2 = 8'(((rx << 7) & 'h80) | ((lt << 2) & 'h60) | (ry & 'h1F));
            r.b3 = 8'(((lt << 5) & 'hE0) | (rt & 'h1F));
            r.b4 = hi_b;
            r.b5 = lo_b;
            r.b6 = 8'd0;
            r.b7 = 8'd0;
            r.len = 4'd6;
        end
        return r;
    endfunction

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout with %0d reports outstanding", expected_reports.size());
            $display("FAIL gamepad_axis_calibrate_and_pack");
            $finish;
        end
    end

    // Driver: present the next request, hold it until accepted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_reports.push_back(build_report({left_x, left_y, right_x, right_y,
                                                         left_trigger, right_trigger,
                                                         button_bits}));
                samples_sent <= samples_sent + 1;
            end
            if (!(start && busy)) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    {left_x, left_y, right_x, right_y, left_trigger, right_trigger,
                     button_bits} <= s;
                    start <= 1'b1;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed report against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && done) begin
            report_t got, want;
            got = '{byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, report_length};
            reports_seen <= reports_seen + 1;
            if (expected_reports.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected report %h", got);
            end
            else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("report mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_LEFT_BOUNDS:    lbounds = val;
            REG_RIGHT_BOUNDS:   rbounds = val;
            REG_LEFT_DEADZONE:  ldz = val[7:0];
            REG_RIGHT_DEADZONE: rdz = val[7:0];
            REG_INVERT_MASK:    inv_bits = val[5:0];
            REG_ENABLE_MASK:    en_bits = val[2:0];
            REG_FULL_REPORT:    full_mode = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Let every queued request go and every report come back.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_samples.size() > 0 || start || expected_reports.size() > 0)
               && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (25) @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s = 63'({$urandom, $urandom});
        // Bias some samples toward the center so the deadzone gets exercised.
        if ($urandom_range(3) == 0) begin
            s.lx = 8'(128 + $urandom_range(24) - 12);
            s.ly = 8'(128 + $urandom_range(24) - 12);
            s.rx = 8'(128 + $urandom_range(24) - 12);
            s.ry = 8'(128 + $urandom_range(24) - 12);
        end
        return s;
    endfunction

    task automatic random_config();
        write_reg(REG_LEFT_BOUNDS, $urandom_range(3) == 0 ? $urandom
                                   : {8'($urandom_range(255, 160)), 8'($urandom_range(255, 160)),
                                      8'($urandom_range(96)), 8'($urandom_range(96))});
        write_reg(REG_RIGHT_BOUNDS, $urandom_range(3) == 0 ? $urandom
                                    : {8'($urandom_range(255, 160)), 8'($urandom_range(255, 160)),
                                       8'($urandom_range(96)), 8'($urandom_range(96))});
        write_reg(REG_LEFT_DEADZONE, $urandom_range(3) == 0 ? $urandom_range(255)
                                     : $urandom_range(30));
        write_reg(REG_RIGHT_DEADZONE, $urandom_range(3) == 0 ? $urandom_range(255)
                                      : $urandom_range(30));
        write_reg(REG_INVERT_MASK, $urandom_range(63));
        write_reg(REG_ENABLE_MASK, $urandom_range(7));
        write_reg(REG_FULL_REPORT, $urandom_range(1));
    endtask

    initial begin
        sample_t s;
        lbounds = 32'hFFFF0000; rbounds = 32'hFFFF0000;
        ldz = 8'd10; rdz = 8'd10;
        inv_bits = '0; en_bits = 3'd3; full_mode = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: field extremes, deadzone edge and digital triggers at defaults.
        pending_samples.push_back('0);
        pending_samples.push_back('1);
        pending_samples.push_back({8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 15'h7FFF});
        pending_samples.push_back({8'd138, 8'd128, 8'd128, 8'd137, 8'd255, 8'd0, 15'h0000});
        pending_samples.push_back({8'd135, 8'd135, 8'd121, 8'd121, 8'd1, 8'd254, 15'h1100});
        drain();

        // Directed: equal and crossed bounds, full report, analog triggers, inversion.
        write_reg(REG_LEFT_BOUNDS, 32'h5050_5050);
        write_reg(REG_RIGHT_BOUNDS, 32'h1010_F0F0);
        write_reg(REG_LEFT_DEADZONE, 8'd0);
        write_reg(REG_RIGHT_DEADZONE, 8'd255);
        write_reg(REG_INVERT_MASK, 6'h3F);
        write_reg(REG_ENABLE_MASK, 3'd7);
        write_reg(REG_FULL_REPORT, 1'b1);
        pending_samples.push_back({8'h50, 8'h50, 8'd0, 8'd0, 8'd0, 8'd255, 15'h5555});
        pending_samples.push_back({8'h4F, 8'h51, 8'd255, 8'd255, 8'd255, 8'd0, 15'h2AAA});
        pending_samples.push_back({8'hFF, 8'h00, 8'hF0, 8'h10, 8'd128, 8'd127, 15'h7FFF});
        drain();
        write_reg(REG_RIGHT_DEADZONE, 8'd0);
        write_reg(REG_RIGHT_BOUNDS, 32'hFFFF0000);
        write_reg(REG_FULL_REPORT, 1'b0);
        // Unknown register index must leave every register alone.
        write_reg(3'd7, 32'hFFFF_FFFF);
        pending_samples.push_back({8'h50, 8'h50, 8'hF0, 8'h10, 8'd0, 8'd255, 15'h0F0F});
        pending_samples.push_back({8'h00, 8'hFF, 8'h00, 8'hFF, 8'd255, 8'd0, 15'h70F0});
        drain();

        for (int phase = 0; phase < 15; phase++) begin
            idle_pct = phase < 5 ? 21 : (phase < 10 ? 58 : 0);
            random_config();
            for (int k = 0; k < 127; k++) begin
                s = random_sample();
                pending_samples.push_back(s);
            end
            drain();
        end

        $display("covered %0d samples, %0d reports, register sweeps incl. extremes",
                 samples_sent, reports_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS gamepad_axis_calibrate_and_pack");
        else
            $display("FAIL gamepad_axis_calibrate_and_pack");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/gacp_pkg.sv
hdl/gacp_stick_lane.sv
hdl/gacp_pack.sv
hdl/gamepad_axis_calibrate_and_pack.sv
bench/gamepad_axis_calibrate_and_pack_test.sv
